// File: design/oate_pkg.sv
// ----------------------------------------------------------------------------
// oate_pkg
// shared types and codes of the ordered array table engine
// ----------------------------------------------------------------------------
package oate_pkg;

  localparam int DEPTH_DEFAULT = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_BAD_OP   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DELETE,
    ST_TRAVERSE,
    ST_SEARCH
  } state_t;

endpackage

// File: design/ordered_array_table_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// dense ordered list of signed words in one memory, with insert, delete,
// update, linear search and traverse
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         start while busy is low   mode, position, value
//  result    out        strobe, one cycle         status, found_position,
//                                                 element, entry_count, last
//
//  update, check, invalid operations and rejected requests give their
//  beat in the cycle after the request; busy stays high while an insert
//  moves entries tail-first or a delete moves them hole-first, while a
//  traverse reads each entry (one beat per entry) and while a search reads
//  up to the first hit; each beat shows in the cycle after the cycle that
//  forms it, with one memory access per cycle. rst clears the count and
//  the control state; memory words are only used after they were written.
//  results cannot be stalled.
// ----------------------------------------------------------------------------
module ordered_array_table_engine #(
  parameter int DEPTH = oate_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [oate_pkg::MODE_W-1:0]         mode,
  input  logic [oate_pkg::POS_W-1:0]          position,
  input  logic signed [oate_pkg::DATA_W-1:0]  value,
  output logic                                strobe,
  output logic [oate_pkg::STATUS_W-1:0]       status,
  output logic [oate_pkg::POS_W-1:0]          found_position,
  output logic signed [oate_pkg::DATA_W-1:0]  element,
  output logic [oate_pkg::POS_W-1:0]          entry_count,
  output logic                                last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > oate_pkg::POS_W) ? CW : oate_pkg::POS_W;
  localparam int DW = oate_pkg::DATA_W;

  oate_pkg::state_t state, state_next;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic [DW-1:0] wdata;
  logic          we;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [AW-1:0] pidx, pidx_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic          pend, pend_next;
  logic [DW-1:0] val_q;

  logic                           emit;
  logic [oate_pkg::STATUS_W-1:0]  emit_status;
  logic [oate_pkg::POS_W-1:0]     emit_pos;
  logic [DW-1:0]                  emit_elem;
  logic                           emit_last;

  logic [PW:0] pos_x, cnt_x;
  logic        is_empty, is_full, bad_ins, bad_upd;
  logic        ins_more, del_more, walk_more, hit;
  logic        accept;

  assign busy   = (state != oate_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign pos_x    = (PW + 1)'(position);
  assign cnt_x    = (PW + 1)'(count);
  assign is_empty = (count == '0);
  assign is_full  = (cnt_x >= (PW + 1)'(DEPTH));
  assign bad_ins  = (pos_x == '0) || (pos_x > cnt_x + 1'b1);
  assign bad_upd  = (pos_x == '0) || (pos_x > cnt_x);

  assign ins_more  = (idx > CW'(pidx));
  assign del_more  = (({1'b0, idx} + 1'b1) < {1'b0, count});
  assign walk_more = (idx < count);
  assign hit       = pend && (rdata == val_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oate_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            oate_pkg::MODE_INSERT: begin
              if (!is_full && !bad_ins) state_next = oate_pkg::ST_INSERT;
            end
            oate_pkg::MODE_DELETE: begin
              if (!is_empty && !bad_upd) state_next = oate_pkg::ST_DELETE;
            end
            oate_pkg::MODE_TRAVERSE: begin
              if (!is_empty) state_next = oate_pkg::ST_TRAVERSE;
            end
            oate_pkg::MODE_SEARCH: begin
              if (!is_empty) state_next = oate_pkg::ST_SEARCH;
            end
            default: state_next = oate_pkg::ST_IDLE;
          endcase
        end
      end
      oate_pkg::ST_INSERT: begin
        if (!ins_more && !pend) state_next = oate_pkg::ST_IDLE;
      end
      oate_pkg::ST_DELETE: begin
        if (!del_more && !pend) state_next = oate_pkg::ST_IDLE;
      end
      oate_pkg::ST_TRAVERSE: begin
        if (!walk_more) state_next = oate_pkg::ST_IDLE;
      end
      oate_pkg::ST_SEARCH: begin
        if (hit || !walk_more) state_next = oate_pkg::ST_IDLE;
      end
      default: state_next = oate_pkg::ST_IDLE;
    endcase
  end

  // memory control, counters and result beat
  always_comb begin
    we             = 1'b0;
    waddr          = pend_addr;
    wdata          = rdata;
    raddr          = idx[AW-1:0];
    count_next     = count;
    idx_next       = idx;
    pidx_next      = pidx;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    emit           = 1'b0;
    emit_status    = oate_pkg::STATUS_OK;
    emit_pos       = '0;
    emit_elem      = '0;
    emit_last      = 1'b1;
    unique case (state)
      oate_pkg::ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          unique case (mode)
            oate_pkg::MODE_INSERT: begin
              if (is_full) begin
                emit_status = oate_pkg::STATUS_FULL;
              end else if (bad_ins) begin
                emit_status = oate_pkg::STATUS_BAD_POS;
              end else begin
                emit      = 1'b0;
                idx_next  = count;
                pidx_next = AW'(position - 1'b1);
              end
            end
            oate_pkg::MODE_DELETE: begin
              if (is_empty) begin
                emit_status = oate_pkg::STATUS_EMPTY;
              end else if (bad_upd) begin
                emit_status = oate_pkg::STATUS_BAD_POS;
              end else begin
                emit     = 1'b0;
                idx_next = CW'(position - 1'b1);
              end
            end
            oate_pkg::MODE_UPDATE: begin
              if (is_empty) begin
                emit_status = oate_pkg::STATUS_EMPTY;
              end else if (bad_upd) begin
                emit_status = oate_pkg::STATUS_BAD_POS;
              end else begin
                we    = 1'b1;
                waddr = AW'(position - 1'b1);
                wdata = value;
              end
            end
            oate_pkg::MODE_TRAVERSE, oate_pkg::MODE_SEARCH: begin
              if (is_empty) begin
                emit_status = oate_pkg::STATUS_EMPTY;
              end else begin
                emit     = 1'b0;
                idx_next = '0;
              end
            end
            oate_pkg::MODE_CHECK: emit_status = oate_pkg::STATUS_OK;
            default:              emit_status = oate_pkg::STATUS_BAD_OP;
          endcase
        end
      end
      oate_pkg::ST_INSERT: begin
        // move entries right, from the tail down to the insert point
        if (pend) begin
          we = 1'b1;
        end
        if (ins_more) begin
          raddr          = AW'(idx - 1'b1);
          pend_next      = 1'b1;
          pend_addr_next = idx[AW-1:0];
          idx_next       = idx - 1'b1;
        end else if (!pend) begin
          we         = 1'b1;
          waddr      = pidx;
          wdata      = val_q;
          count_next = count + 1'b1;
          emit       = 1'b1;
        end
      end
      oate_pkg::ST_DELETE: begin
        // move entries left, from the hole up to the tail
        if (pend) begin
          we = 1'b1;
        end
        if (del_more) begin
          raddr          = AW'(idx + 1'b1);
          pend_next      = 1'b1;
          pend_addr_next = idx[AW-1:0];
          idx_next       = idx + 1'b1;
        end else if (!pend) begin
          count_next = count - 1'b1;
          emit       = 1'b1;
        end
      end
      oate_pkg::ST_TRAVERSE: begin
        if (pend) begin
          emit      = 1'b1;
          emit_pos  = oate_pkg::POS_W'(PW'(pend_addr) + 1'b1);
          emit_elem = rdata;
          emit_last = ((CW'(pend_addr) + 1'b1) == count);
        end
        if (walk_more) begin
          pend_next      = 1'b1;
          pend_addr_next = idx[AW-1:0];
          idx_next       = idx + 1'b1;
        end
      end
      oate_pkg::ST_SEARCH: begin
        if (hit) begin
          emit     = 1'b1;
          emit_pos = oate_pkg::POS_W'(PW'(pend_addr) + 1'b1);
        end else if (!walk_more) begin
          emit        = 1'b1;
          emit_status = oate_pkg::STATUS_NOT_FOUND;
        end else begin
          pend_next      = 1'b1;
          pend_addr_next = idx[AW-1:0];
          idx_next       = idx + 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= oate_pkg::ST_IDLE;
      count  <= '0;
      pend   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      pend   <= pend_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx            <= idx_next;
    pidx           <= pidx_next;
    pend_addr      <= pend_addr_next;
    if (accept) begin
      val_q <= value;
    end
    status         <= emit_status;
    found_position <= emit_pos;
    element        <= emit_elem;
    entry_count    <= oate_pkg::POS_W'(count_next);
    last           <= emit_last;
  end

endmodule

// File: tb/ordered_array_table_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_table_engine_tb
// drives insert, delete, update, search, traverse and check requests, keeps
// its own copy of the list to predict every result beat, and checks each beat
// field by field in arrival order; random idle bursts on the request side
// ----------------------------------------------------------------------------
module ordered_array_table_engine_tb;

  localparam int LIST_DEPTH   = oate_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_TAIL   = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [oate_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [oate_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic [oate_pkg::MODE_W-1:0]         mode;
    logic [oate_pkg::POS_W-1:0]          position;
    logic signed [oate_pkg::DATA_W-1:0]  value;
  } list_req_t;

  typedef struct packed {
    logic [oate_pkg::STATUS_W-1:0]       status;
    logic [oate_pkg::POS_W-1:0]          found_position;
    logic signed [oate_pkg::DATA_W-1:0]  element;
    logic [oate_pkg::POS_W-1:0]          entry_count;
    logic                                last;
  } list_beat_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  start;
  logic                                  busy;
  logic [oate_pkg::MODE_W-1:0]           mode;
  logic [oate_pkg::POS_W-1:0]            position;
  logic signed [oate_pkg::DATA_W-1:0]    value;
  logic                                  strobe;
  logic [oate_pkg::STATUS_W-1:0]         status;
  logic [oate_pkg::POS_W-1:0]            found_position;
  logic signed [oate_pkg::DATA_W-1:0]    element;
  logic [oate_pkg::POS_W-1:0]            entry_count;
  logic                                  last;

  list_req_t                             req_q[$];
  list_beat_t                            beats_due[$];
  logic signed [oate_pkg::DATA_W-1:0]    shadow_list[LIST_DEPTH];
  int unsigned                           shadow_len;
  int unsigned                           gen_len;
  logic signed [oate_pkg::DATA_W-1:0]    value_pool[8];
  int                                    err_count;
  int                                    stall_cycles;
  int                                    gap_left;
  bit                                    idle_on;
  bit                                    beat_taken;

  int op_cuts[3][7] = '{
    '{80, 82, 86, 91, 98, 99, 100},
    '{25, 45, 55, 70, 90, 95, 100},
    '{ 5, 70, 78, 85, 95, 98, 100}
  };
  logic [oate_pkg::MODE_W-1:0] op_menu[7] = '{
    oate_pkg::MODE_INSERT, oate_pkg::MODE_DELETE, oate_pkg::MODE_TRAVERSE,
    oate_pkg::MODE_UPDATE, oate_pkg::MODE_SEARCH, oate_pkg::MODE_CHECK, MODE_RSVD6};

  ordered_array_table_engine #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .position(position),
    .value(value),
    .strobe(strobe),
    .status(status),
    .found_position(found_position),
    .element(element),
    .entry_count(entry_count),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic void expect_beat(logic [oate_pkg::STATUS_W-1:0] st, int unsigned pos,
                                      logic signed [oate_pkg::DATA_W-1:0] elem, bit fin);
    list_beat_t b;
    b.status         = st;
    b.found_position = pos[oate_pkg::POS_W-1:0];
    b.element        = elem;
    b.entry_count    = shadow_len[oate_pkg::POS_W-1:0];
    b.last           = fin;
    beats_due.push_back(b);
  endfunction

  function automatic void apply_list_op(logic [oate_pkg::MODE_W-1:0] op,
                                        logic [oate_pkg::POS_W-1:0] pos,
                                        logic signed [oate_pkg::DATA_W-1:0] val);
    int p;
    int hit;
    p   = pos;
    hit = 0;
    case (op)
      oate_pkg::MODE_INSERT: begin
        if (shadow_len >= LIST_DEPTH) begin
          expect_beat(oate_pkg::STATUS_FULL, 0, 0, 1'b1);
        end else if (p < 1 || p > shadow_len + 1) begin
          expect_beat(oate_pkg::STATUS_BAD_POS, 0, 0, 1'b1);
        end else begin
          for (int i = shadow_len; i >= p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
          expect_beat(oate_pkg::STATUS_OK, 0, 0, 1'b1);
        end
      end
      oate_pkg::MODE_DELETE, oate_pkg::MODE_UPDATE: begin
        if (shadow_len == 0) begin
          expect_beat(oate_pkg::STATUS_EMPTY, 0, 0, 1'b1);
        end else if (p < 1 || p > shadow_len) begin
          expect_beat(oate_pkg::STATUS_BAD_POS, 0, 0, 1'b1);
        end else begin
          if (op == oate_pkg::MODE_UPDATE) begin
            shadow_list[p-1] = val;
          end else begin
            for (int i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
            shadow_len--;
          end
          expect_beat(oate_pkg::STATUS_OK, 0, 0, 1'b1);
        end
      end
      oate_pkg::MODE_TRAVERSE: begin
        if (shadow_len == 0) begin
          expect_beat(oate_pkg::STATUS_EMPTY, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            expect_beat(oate_pkg::STATUS_OK, i + 1, shadow_list[i], i + 1 == shadow_len);
        end
      end
      oate_pkg::MODE_SEARCH: begin
        if (shadow_len == 0) begin
          expect_beat(oate_pkg::STATUS_EMPTY, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len && hit == 0; i++)
            if (shadow_list[i] == val) hit = i + 1;
          if (hit != 0) expect_beat(oate_pkg::STATUS_OK, hit, 0, 1'b1);
          else expect_beat(oate_pkg::STATUS_NOT_FOUND, 0, 0, 1'b1);
        end
      end
      oate_pkg::MODE_CHECK: expect_beat(oate_pkg::STATUS_OK, 0, 0, 1'b1);
      default: expect_beat(oate_pkg::STATUS_BAD_OP, 0, 0, 1'b1);
    endcase
  endfunction

  // tracks only the list length, to aim positions at the valid range
  function automatic void queue_req(logic [oate_pkg::MODE_W-1:0] op, int unsigned pos,
                                    logic signed [oate_pkg::DATA_W-1:0] val);
    list_req_t r;
    r.mode     = op;
    r.position = pos[oate_pkg::POS_W-1:0];
    r.value    = val;
    req_q.push_back(r);
    if (op == oate_pkg::MODE_INSERT && gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1)
      gen_len++;
    else if (op == oate_pkg::MODE_DELETE && gen_len > 0 && pos >= 1 && pos <= gen_len)
      gen_len--;
  endfunction

  function automatic logic signed [oate_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // driver
  always @(negedge clk) begin
    list_req_t nxt;
    logic      drive;
    if (rst) begin
      start <= 1'b0;
    end else begin
      drive = start && !beat_taken;
      if (start && beat_taken) begin
        if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        if (idle_on && req_q.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 8);
      end
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          nxt = req_q.pop_front();
          mode     <= nxt.mode;
          position <= nxt.position;
          value    <= nxt.value;
          drive    = 1'b1;
        end
      end
      start <= drive;
    end
  end

  // monitor and request capture
  always @(posedge clk) begin
    list_beat_t got;
    list_beat_t want;
    beat_taken = 1'b0;
    if (!rst) begin
      if (strobe === 1'b1) begin
        got = '{status, found_position, element, entry_count, last};
        if (beats_due.size() == 0) begin
          report($sformatf("unexpected beat status %0d count %0d", status, entry_count));
        end else begin
          want = beats_due.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.found_position !== want.found_position)
            report($sformatf("found_position %0d, want %0d",
                             got.found_position, want.found_position));
          if (got.element !== want.element)
            report($sformatf("element %0d, want %0d", got.element, want.element));
          if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, want %0d", got.entry_count, want.entry_count));
          if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
      if (start && !busy) begin
        beat_taken = 1'b1;
        apply_list_op(mode, position, value);
      end
    end
    stall_cycles = (beat_taken || strobe === 1'b1) ? 0 : stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("%0t ns watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("ordered_array_table_engine_tb: done, errors");
    $finish;
  end

  initial begin
    int phase;
    int r;
    int k;
    logic [oate_pkg::MODE_W-1:0] op;
    int unsigned pos;
    start        = 1'b0;
    mode         = oate_pkg::MODE_CHECK;
    position     = '0;
    value        = '0;
    rst          = 1'b1;
    err_count    = 0;
    stall_cycles = 0;
    gap_left     = 0;
    idle_on      = 1'b1;
    beat_taken   = 1'b0;
    shadow_len   = 0;
    gen_len      = 0;
    value_pool   = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1,
                     $urandom, $urandom, $urandom};

    // empty list, reserved modes, bad positions, ends and duplicates
    queue_req(oate_pkg::MODE_CHECK, 0, 0);
    queue_req(oate_pkg::MODE_DELETE, 1, 0);
    queue_req(oate_pkg::MODE_UPDATE, 1, 5);
    queue_req(oate_pkg::MODE_SEARCH, 0, 0);
    queue_req(oate_pkg::MODE_TRAVERSE, 0, 0);
    queue_req(MODE_RSVD6, 1, -1);
    queue_req(MODE_RSVD7, 63, 32'sh7fff_ffff);
    queue_req(oate_pkg::MODE_INSERT, 0, 9);
    queue_req(oate_pkg::MODE_INSERT, 2, 9);
    queue_req(oate_pkg::MODE_INSERT, 1, 32'sh8000_0000);
    queue_req(oate_pkg::MODE_INSERT, 2, 32'sh7fff_ffff);
    queue_req(oate_pkg::MODE_INSERT, 1, 0);
    queue_req(oate_pkg::MODE_INSERT, 63, 7);
    queue_req(oate_pkg::MODE_TRAVERSE, 63, 0);
    queue_req(oate_pkg::MODE_SEARCH, 0, 32'sh7fff_ffff);
    queue_req(oate_pkg::MODE_SEARCH, 0, 12345);
    queue_req(oate_pkg::MODE_UPDATE, 3, -1);
    queue_req(oate_pkg::MODE_UPDATE, 0, 4);
    queue_req(oate_pkg::MODE_UPDATE, 4, 4);
    queue_req(oate_pkg::MODE_DELETE, 4, 0);
    queue_req(oate_pkg::MODE_DELETE, 0, 0);
    queue_req(oate_pkg::MODE_INSERT, 2, -1);
    queue_req(oate_pkg::MODE_SEARCH, 0, -1);
    queue_req(oate_pkg::MODE_DELETE, 2, 0);
    queue_req(oate_pkg::MODE_CHECK, 17, 0);

    // fill, mixed and drain phases in turn
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 50) % 3;
      r = $urandom_range(0, 99);
      k = 0;
      while (k < 6 && r >= op_cuts[phase][k]) k++;
      op = op_menu[k];
      if (op == MODE_RSVD6 && $urandom_range(0, 1) == 1) op = MODE_RSVD7;
      pos = $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 85) begin
        if (op == oate_pkg::MODE_INSERT)
          pos = $urandom_range(1, gen_len + 1);
        else if ((op == oate_pkg::MODE_DELETE || op == oate_pkg::MODE_UPDATE) && gen_len > 0)
          pos = $urandom_range(1, gen_len);
      end
      queue_req(op, pos, pick_value());
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (req_q.size() != 0 || start || beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && beats_due.size() == 0) begin
      $display("ordered_array_table_engine_tb: done, clean");
    end else begin
      $display("ordered_array_table_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
